/* sv/text_cell_buffer_macros.svh */
// ----------------------------------------------------------------------------
// Text cell buffer assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_BUFFER_MACROS_SVH
`define TEXT_CELL_BUFFER_MACROS_SVH

// Same-cycle implication
`define TCB_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication
`define TCB_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* sv/tcb_pkg.sv */
// ----------------------------------------------------------------------------
// Text cell buffer package
// Field widths, opcodes, register indexes, word types and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tcb_pkg;

   // Store geometry
   localparam int MAX_COLUMNS  = 128;
   localparam int MAX_ROWS     = 64;
   localparam int COL_W        = 7;
   localparam int ROW_W        = 6;
   localparam int ADDR_W       = COL_W + ROW_W;
   localparam int STORE_DEPTH  = MAX_COLUMNS * MAX_ROWS;

   // Field widths
   localparam int OPCODE_W     = 3;
   localparam int COORD_W      = 16;
   localparam int CHAR_W       = 8;
   localparam int COLOUR_W     = 4;
   localparam int WIDTH_REG_W  = 8;
   localparam int HEIGHT_REG_W = 7;
   localparam int PROD_W       = ROW_W + WIDTH_REG_W;

   // Configuration port
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_FORE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_BACK  = 2'd3;

   localparam logic [WIDTH_REG_W-1:0]  GRID_WIDTH_RST  = 8'd80;
   localparam logic [HEIGHT_REG_W-1:0] GRID_HEIGHT_RST = 7'd25;
   localparam logic [COLOUR_W-1:0]     CLEAR_FORE_RST  = 4'h7;
   localparam logic [COLOUR_W-1:0]     CLEAR_BACK_RST  = 4'h0;

   // Answer for a read with the cursor off the grid
   localparam logic [CHAR_W-1:0]   SPACE_CHAR = 8'h20;
   localparam logic [COLOUR_W-1:0] BLANK_FORE = 4'h7;
   localparam logic [COLOUR_W-1:0] BLANK_BACK = 4'h0;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_CLEAR       = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SET_CURSOR  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_MOVE_CURSOR = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_WRITE_POS   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_WRITE_CUR   = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_READ        = 3'd5;

   // Remainder unit: signed 17-bit operand, 16-bit magnitude, 4 bits a cycle
   localparam int WRAP_IN_W   = COORD_W + 1;
   localparam int WRAP_MAG_W  = COORD_W;
   localparam int DIV_W       = WIDTH_REG_W;
   localparam int WRAP_BITS   = 4;
   localparam int WRAP_ROUNDS = WRAP_MAG_W / WRAP_BITS;
   localparam int WRAP_CNT_W  = $clog2(WRAP_ROUNDS);

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] move_dx;
      logic signed [COORD_W-1:0] move_dy;
      logic [CHAR_W-1:0]         char_code;
      logic [COLOUR_W-1:0]       fore_colour;
      logic                      fore_keep;
      logic [COLOUR_W-1:0]       back_colour;
      logic                      back_keep;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   read_char;
      logic [COLOUR_W-1:0] read_fore;
      logic [COLOUR_W-1:0] read_back;
      logic [COL_W-1:0]    cursor_col;
      logic [ROW_W-1:0]    cursor_row;
   } rsp_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   char_code;
      logic [COLOUR_W-1:0] fore;
      logic [COLOUR_W-1:0] back;
   } cell_type;

   typedef struct packed {
      logic capture;
      logic sweep_start;
      logic sweep_write;
      logic wrap_start;
      logic cursor_update;
      logic addr_calc;
      logic mem_read;
      logic merge_write;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic wrap_done;
      logic rsp_free;
   } dp_sts_type;

endpackage

/* sv/text_cell_buffer.sv */
// ----------------------------------------------------------------------------
// Text cell buffer
// Character cell store of up to 128 x 64 cells with cursor, clear, cell
// merge writes and cursor reads. One result word per request word.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Word
//   req_      in         req_valid / req_ready  tcb_pkg::req_type
//   rsp_      out        rsp_valid / rsp_ready  tcb_pkg::rsp_type
//   csr_      in         csr_wen                csr_index, csr_wdata
//
// Reads and writes are paced by the single-port read-modify-write on the cell
// memory, cursor ops by the 4-bit-per-cycle remainder unit, and clear by one
// memory write per cycle over all 8192 cells.
// After reset a clearing pass over all 8192 cells runs before req_ready rises.
// A stalled result stays in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module text_cell_buffer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tcb_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tcb_pkg::rsp_type                rsp_data,
   input  logic                            csr_wen,
   input  logic [tcb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tcb_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   tcb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   tcb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

/* sv/tcb_wrap.sv */
// ----------------------------------------------------------------------------
// Text cell buffer wrap unit
// Signed operand modulo an unsigned divisor, result in [0, divisor).
// Restoring remainder over the magnitude, WRAP_BITS bits per cycle.
// ----------------------------------------------------------------------------
module tcb_wrap (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tcb_pkg::WRAP_IN_W-1:0]  operand,
   input  logic [tcb_pkg::DIV_W-1:0]      divisor,
   output logic                           done,
   output logic [tcb_pkg::DIV_W-1:0]      result
);
   import tcb_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [WRAP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [WRAP_MAG_W-1:0]  mag_ff, mag_in;
   logic [DIV_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]       div_ff, div_in;

   logic [WRAP_IN_W-1:0]   abs_operand;
   logic [DIV_W-1:0]       rem_step;
   logic [WRAP_MAG_W-1:0]  mag_step;

   // Operands stay within 16 bits of magnitude
   assign abs_operand = operand[WRAP_IN_W-1] ? (~operand + WRAP_IN_W'(1)) : operand;

   always_comb begin : steps
      logic [DIV_W-1:0]      r;
      logic [WRAP_MAG_W-1:0] m;
      r = rem_ff;
      m = mag_ff;
      for (int i = 0; i < WRAP_BITS; i++) begin
         r = {r[DIV_W-2:0], m[WRAP_MAG_W-1]};
         m = {m[WRAP_MAG_W-2:0], 1'b0};
         if (r >= div_ff) begin
            r = r - div_ff;
         end
      end
      rem_step = r;
      mag_step = m;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      priority if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = operand[WRAP_IN_W-1];
         mag_in  = abs_operand[WRAP_MAG_W-1:0];
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         mag_in = mag_step;
         rem_in = rem_step;
         cnt_in = cnt_ff + WRAP_CNT_W'(1);
         if (cnt_ff == WRAP_CNT_W'(WRAP_ROUNDS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   // Fold a negative remainder back into range
   assign done   = done_ff;
   assign result = (neg_ff && (rem_ff != '0)) ? (div_ff - rem_ff) : rem_ff;

endmodule

/* sv/tcb_dp.sv */
// ----------------------------------------------------------------------------
// Text cell buffer datapath
// Configuration registers, cursor, cell memory with read-modify-write,
// clearing sweep, cursor wrap units and the result register.
// ----------------------------------------------------------------------------
module tcb_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  tcb_pkg::req_type                req_data,
   input  logic                            csr_wen,
   input  logic [tcb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tcb_pkg::rsp_type                rsp_data,
   input  tcb_pkg::dp_cmd_type             cmd,
   output tcb_pkg::dp_sts_type             sts
);
   import tcb_pkg::*;

   // Configuration
   logic [WIDTH_REG_W-1:0]  grid_width_ff, grid_width_in;
   logic [HEIGHT_REG_W-1:0] grid_height_ff, grid_height_in;
   logic [COLOUR_W-1:0]     clear_fore_ff, clear_fore_in;
   logic [COLOUR_W-1:0]     clear_back_ff, clear_back_in;
   logic [WIDTH_REG_W-1:0]  eff_width;
   logic [HEIGHT_REG_W-1:0] eff_height;

   // Item and cursor
   req_type                 req_ff, req_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;

   // Wrap units
   logic [WRAP_IN_W-1:0]    col_operand, row_operand;
   logic [DIV_W-1:0]        col_result, row_result;
   logic                    col_done, row_done;
   logic                    set_op;

   // Addressing
   logic [COORD_W-1:0]      x_coord, y_coord;
   logic [PROD_W-1:0]       row_offset;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic                    hit_ff, hit_in;

   // Memory and sweep
   cell_type                cell_mem [STORE_DEPTH];
   cell_type                rdata_ff;
   cell_type                merged;
   cell_type                fill_ff, fill_in;
   logic [ADDR_W-1:0]       sweep_ff, sweep_in;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   cell_type                mem_wdata;

   // Result
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Configuration writes
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      clear_fore_in  = clear_fore_ff;
      clear_back_in  = clear_back_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_wdata[WIDTH_REG_W-1:0];
            CSR_GRID_HEIGHT: grid_height_in = csr_wdata[HEIGHT_REG_W-1:0];
            CSR_CLEAR_FORE:  clear_fore_in  = csr_wdata[COLOUR_W-1:0];
            CSR_CLEAR_BACK:  clear_back_in  = csr_wdata[COLOUR_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero acts as one, oversize clamps to the store
   always_comb begin
      priority if (grid_width_ff == '0) begin
         eff_width = WIDTH_REG_W'(1);
      end else if (grid_width_ff > WIDTH_REG_W'(MAX_COLUMNS)) begin
         eff_width = WIDTH_REG_W'(MAX_COLUMNS);
      end else begin
         eff_width = grid_width_ff;
      end
      priority if (grid_height_ff == '0) begin
         eff_height = HEIGHT_REG_W'(1);
      end else if (grid_height_ff > HEIGHT_REG_W'(MAX_ROWS)) begin
         eff_height = HEIGHT_REG_W'(MAX_ROWS);
      end else begin
         eff_height = grid_height_ff;
      end
   end

   assign req_in = cmd.capture ? req_data : req_ff;

   // Cursor wrap
   assign set_op      = (req_ff.opcode == OP_SET_CURSOR);
   assign col_operand = set_op ? {req_ff.pos_x[COORD_W-1], req_ff.pos_x}
                               : WRAP_IN_W'(col_ff) + {req_ff.move_dx[COORD_W-1], req_ff.move_dx};
   assign row_operand = set_op ? {req_ff.pos_y[COORD_W-1], req_ff.pos_y}
                               : WRAP_IN_W'(row_ff) + {req_ff.move_dy[COORD_W-1], req_ff.move_dy};

   tcb_wrap u_wrap_col (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.wrap_start),
      .operand (col_operand),
      .divisor (eff_width),
      .done    (col_done),
      .result  (col_result)
   );

   tcb_wrap u_wrap_row (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.wrap_start),
      .operand (row_operand),
      .divisor (DIV_W'(eff_height)),
      .done    (row_done),
      .result  (row_result)
   );

   assign col_in = cmd.cursor_update ? col_result[COL_W-1:0] : col_ff;
   assign row_in = cmd.cursor_update ? row_result[ROW_W-1:0] : row_ff;

   // Cell address: x + y * width
   assign x_coord    = (req_ff.opcode == OP_WRITE_POS) ? req_ff.pos_x : COORD_W'(col_ff);
   assign y_coord    = (req_ff.opcode == OP_WRITE_POS) ? req_ff.pos_y : COORD_W'(row_ff);
   assign row_offset = PROD_W'(y_coord[ROW_W-1:0]) * PROD_W'(eff_width);

   always_comb begin
      addr_in = addr_ff;
      hit_in  = hit_ff;
      if (cmd.addr_calc) begin
         addr_in = ADDR_W'(PROD_W'(x_coord[COL_W-1:0]) + row_offset);
         hit_in  = !x_coord[COORD_W-1] && !y_coord[COORD_W-1]
                   && (x_coord < COORD_W'(eff_width))
                   && (y_coord < COORD_W'(eff_height));
      end
   end

   // Merge: zero character and keep flags hold the stored field
   always_comb begin
      merged.char_code = (req_ff.char_code != '0) ? req_ff.char_code : rdata_ff.char_code;
      merged.fore      = req_ff.fore_keep ? rdata_ff.fore : req_ff.fore_colour;
      merged.back      = req_ff.back_keep ? rdata_ff.back : req_ff.back_colour;
   end

   // Clearing sweep
   always_comb begin
      sweep_in = sweep_ff;
      fill_in  = fill_ff;
      priority if (cmd.sweep_start) begin
         sweep_in = '0;
         fill_in  = '{char_code: '0, fore: clear_fore_ff, back: clear_back_ff};
      end else if (cmd.sweep_write) begin
         sweep_in = sweep_ff + ADDR_W'(1);
      end else begin
         sweep_in = sweep_ff;
      end
   end

   assign mem_we    = cmd.sweep_write || (cmd.merge_write && hit_ff);
   assign mem_waddr = cmd.sweep_write ? sweep_ff : addr_ff;
   assign mem_wdata = cmd.sweep_write ? fill_ff : merged;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         rdata_ff <= cell_mem[addr_ff];
      end
   end

   // Result word
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_rsp) begin
         rsp_valid_in      = 1'b1;
         rsp_in.read_char  = '0;
         rsp_in.read_fore  = '0;
         rsp_in.read_back  = '0;
         rsp_in.cursor_col = col_ff;
         rsp_in.cursor_row = row_ff;
         if (req_ff.opcode == OP_READ) begin
            if (hit_ff) begin
               rsp_in.read_char = rdata_ff.char_code;
               rsp_in.read_fore = rdata_ff.fore;
               rsp_in.read_back = rdata_ff.back;
            end else begin
               rsp_in.read_char = SPACE_CHAR;
               rsp_in.read_fore = BLANK_FORE;
               rsp_in.read_back = BLANK_BACK;
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RST;
         grid_height_ff <= GRID_HEIGHT_RST;
         clear_fore_ff  <= CLEAR_FORE_RST;
         clear_back_ff  <= CLEAR_BACK_RST;
         col_ff         <= '0;
         row_ff         <= '0;
         sweep_ff       <= '0;
         fill_ff        <= '{char_code: '0, fore: CLEAR_FORE_RST, back: CLEAR_BACK_RST};
         rsp_valid_ff   <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         clear_fore_ff  <= clear_fore_in;
         clear_back_ff  <= clear_back_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         sweep_ff       <= sweep_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      addr_ff <= addr_in;
      hit_ff  <= hit_in;
      rsp_ff  <= rsp_in;
   end

   assign sts.sweep_last = (sweep_ff == '1);
   assign sts.wrap_done  = col_done && row_done;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/tcb_ctrl.sv */
// ----------------------------------------------------------------------------
// Text cell buffer controller
// Sequences the clearing sweep, cursor wrap, memory read-modify-write and
// the hand-off of each result word to the output register.
// ----------------------------------------------------------------------------
`include "text_cell_buffer_macros.svh"

module tcb_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [tcb_pkg::OPCODE_W-1:0]   req_opcode,
   output logic                           req_ready,
   output tcb_pkg::dp_cmd_type            cmd,
   input  tcb_pkg::dp_sts_type            sts
);
   import tcb_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_WSTART,
      ST_WRAP,
      ST_ADDR,
      ST_RDMEM,
      ST_MERGE,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [OPCODE_W-1:0]   op_ff, op_in;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep_write = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = req_opcode;
               unique case (req_opcode)
                  OP_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  OP_SET_CURSOR, OP_MOVE_CURSOR: state_in = ST_WSTART;
                  OP_WRITE_POS, OP_WRITE_CUR, OP_READ: state_in = ST_ADDR;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_WSTART: begin
            cmd.wrap_start = 1'b1;
            state_in       = ST_WRAP;
         end
         ST_WRAP: begin
            if (sts.wrap_done) begin
               cmd.cursor_update = 1'b1;
               state_in          = ST_FINISH;
            end
         end
         ST_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in      = ST_RDMEM;
         end
         ST_RDMEM: begin
            cmd.mem_read = 1'b1;
            state_in     = (op_ff == OP_READ) ? ST_FINISH : ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge_write = 1'b1;
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the word
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         op_ff    <= OP_CLEAR;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   `TCB_ASSERT_NOW(a_no_accept_in_sweep, req_ready, !cmd.sweep_write, "item taken during sweep")
   `TCB_ASSERT_NOW(a_rsp_not_overwritten, cmd.load_rsp, sts.rsp_free, "pending word overwritten")
   `TCB_ASSERT_NOW(a_wrap_done_in_wrap, sts.wrap_done, state_ff == ST_WRAP, "stray wrap done")
   `TCB_ASSERT_NEXT(a_clear_ends, state_ff == ST_CLEAR && sts.sweep_last, state_ff == ST_FINISH, "clear did not finish")
   `TCB_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != ST_IDLE, "accept stayed idle")

endmodule
